// ===== sv/indexed_insert_delete_list_defines.svh =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_defines.svh
// Assertion macros shared by the indexed insert/delete list RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_LIST_DEFINES_SVH
`define INDEXED_INSERT_DELETE_LIST_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IIDL_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define IIDL_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

// ===== sv/iidl_pkg.sv =====
// ----------------------------------------------------------------------------
// iidl_pkg
// Types and constants of the indexed insert/delete list.
// ----------------------------------------------------------------------------
package iidl_pkg;

    // Sizing
    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 7;
    localparam int STORE_W     = (VALUE_WIDTH < WORD_W) ? VALUE_WIDTH : WORD_W;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request codes
    localparam logic [2:0] REQ_APPEND  = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_READ    = 3'd2;
    localparam logic [2:0] REQ_DELETE  = 3'd3;
    localparam logic [2:0] REQ_REPLACE = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_SOLE      = 2'd3;

    // Request transaction
    typedef struct packed {
        logic [2:0]        req_type;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] word_in;
    } t_req_item;

    // Response transaction
    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic [1:0]        status;
        logic [6:0]        fill_count;
    } t_rsp_item;

    // Command broadcast to the cell row
    typedef struct packed {
        logic               wr;
        logic               up;
        logic               down;
        logic [IDX_W-1:0]   idx;
        logic [STORE_W-1:0] word;
    } t_chain_cmd;

    // Per-cell select
    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
    } t_cell_ctl;

endpackage

// ===== sv/indexed_insert_delete_list.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Ordered word list with append, insert, read, delete and replace requests.
// ----------------------------------------------------------------------------
// One request transaction is taken per clock cycle while o_in_ready is high,
// and its response appears in the output register on the following cycle;
// o_in_ready stays high as long as the output register is empty or being
// drained. The rate is set by the row of CAPACITY cells; the cells at or above
// the request index all move in the same cycle, so no request type is slower.
// Entries hold no reset value; only entries below the fill count are read.
// ----------------------------------------------------------------------------
`include "indexed_insert_delete_list_defines.svh"

module indexed_insert_delete_list
    import iidl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_req_item i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_rsp_item o_out_data
);

    logic               r_out_valid;
    t_rsp_item          r_out;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic               in_fire;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic               pos_lt_cnt;
    logic               pos_le_cnt;
    logic               full;
    logic [1:0]         st;
    logic               is_read;
    t_chain_cmd         cmd;
    logic [STORE_W-1:0] rd_word;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // Index checks
    assign pos_ext    = CMP_W'(i_in_data.position);
    assign cnt_ext    = CMP_W'(r_count);
    assign pos_lt_cnt = pos_ext < cnt_ext;
    assign pos_le_cnt = pos_ext <= cnt_ext;
    assign full       = (r_count == CNT_W'(CAPACITY));

    // Request decode
    always_comb begin
        st       = ST_OK;
        is_read  = 1'b0;
        cmd.wr   = 1'b0;
        cmd.up   = 1'b0;
        cmd.down = 1'b0;
        cmd.idx  = i_in_data.position[IDX_W-1:0];
        cmd.word = i_in_data.word_in[STORE_W-1:0];
        n_count  = r_count;
        unique case (i_in_data.req_type)
            REQ_APPEND: begin
                cmd.idx = r_count[IDX_W-1:0];
                if (full) begin
                    st = ST_FULL;
                end else begin
                    cmd.wr  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_INSERT: begin
                priority if (!pos_le_cnt) begin
                    st = ST_BAD_INDEX;
                end else if (full) begin
                    st = ST_FULL;
                end else begin
                    cmd.wr  = 1'b1;
                    cmd.up  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_READ: begin
                if (!pos_lt_cnt) begin
                    st = ST_BAD_INDEX;
                end else begin
                    is_read = 1'b1;
                end
            end
            REQ_DELETE: begin
                priority if (!pos_lt_cnt) begin
                    st = ST_BAD_INDEX;
                end else if (r_count <= CNT_W'(1)) begin
                    st = ST_SOLE;
                end else begin
                    cmd.down = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            REQ_REPLACE: begin
                if (!pos_lt_cnt) begin
                    st = ST_BAD_INDEX;
                end else begin
                    cmd.wr = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // Nothing moves unless the transaction is taken
        if (!in_fire) begin
            cmd.wr   = 1'b0;
            cmd.up   = 1'b0;
            cmd.down = 1'b0;
        end
    end

    iidl_chain u_chain (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_rd_idx  (i_in_data.position[IDX_W-1:0]),
        .o_rd_word (rd_word)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_fire) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.word_out   <= is_read ? WORD_W'(rd_word) : '0;
            r_out.status     <= st;
            r_out.fill_count <= 7'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `IIDL_ASSERT_IMPL(a_count_range, 1'b1, r_count <= CNT_W'(CAPACITY), "fill count over capacity")
    `IIDL_ASSERT_NEXT(a_count_grow, in_fire && st == ST_OK && (i_in_data.req_type == REQ_APPEND || i_in_data.req_type == REQ_INSERT), r_count == CNT_W'($past(r_count) + 1'b1), "count did not grow")
    `IIDL_ASSERT_NEXT(a_err_hold, in_fire && st != ST_OK, r_count == $past(r_count), "failed request changed count")
    `IIDL_ASSERT_IMPL(a_full_only, in_fire && st == ST_FULL, full, "full status on non-full list")

endmodule

// ===== sv/iidl_cell.sv =====
// ----------------------------------------------------------------------------
// iidl_cell
// One list entry: loads the new word or takes a neighbor's word.
// ----------------------------------------------------------------------------
module iidl_cell
    import iidl_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [STORE_W-1:0] i_word,
    input  logic [STORE_W-1:0] i_left,
    input  logic [STORE_W-1:0] i_right,
    output logic [STORE_W-1:0] o_word
);

    logic [STORE_W-1:0] r_word;
    logic [STORE_W-1:0] n_word;

    // Select next value; a direct write wins over a shift
    always_comb begin
        priority if (i_ctl.load) begin
            n_word = i_word;
        end else if (i_ctl.from_left) begin
            n_word = i_left;
        end else if (i_ctl.from_right) begin
            n_word = i_right;
        end else begin
            n_word = r_word;
        end
    end

    // Payload register, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== sv/iidl_chain.sv =====
// ----------------------------------------------------------------------------
// iidl_chain
// Row of cells; each cell sees its neighbors and the broadcast command.
// ----------------------------------------------------------------------------
module iidl_chain
    import iidl_pkg::*;
(
    input  logic               i_clk,
    input  t_chain_cmd         i_cmd,
    input  logic [IDX_W-1:0]   i_rd_idx,
    output logic [STORE_W-1:0] o_rd_word
);

    logic [STORE_W-1:0] cell_word [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_cell_ctl          ctl;
            logic [STORE_W-1:0] left;
            logic [STORE_W-1:0] right;
            logic               at_pos;
            logic               above_pos;

            // Where this cell sits relative to the command index
            assign at_pos    = (i_cmd.idx == IDX_W'(gi));
            assign above_pos = (IDX_W'(gi) > i_cmd.idx);

            assign ctl.load       = i_cmd.wr && at_pos;
            assign ctl.from_left  = i_cmd.up && above_pos;
            assign ctl.from_right = i_cmd.down && (above_pos || at_pos);

            // Edge cells get a constant neighbor
            if (gi == 0) begin : g_first
                assign left = '0;
            end else begin : g_left
                assign left = cell_word[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right = '0;
            end else begin : g_right
                assign right = cell_word[gi+1];
            end

            iidl_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_word  (i_cmd.word),
                .i_left  (left),
                .i_right (right),
                .o_word  (cell_word[gi])
            );
        end
    endgenerate

    // Read port
    assign o_rd_word = cell_word[i_rd_idx];

endmodule
